@@ src/fdtb_pkg.sv @@
// Shared types, constants and codes of the fragment depth test and blend unit.
package fdtb_pkg;

  // Store geometry
  localparam int unsigned FB_PIXELS = 65536;
  localparam int unsigned IDX_W     = $clog2(FB_PIXELS);
  localparam int unsigned DEPTH_W   = 24;
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = '1;

  // Queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Result queue
  localparam int unsigned RESQ_DEPTH = 8;
  localparam int unsigned RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int unsigned RESQ_CNT_W = $clog2(RESQ_DEPTH + 4);

  // Divide by 255 as multiply by reciprocal; exact for dividends below 132626
  localparam int unsigned BSUM_W      = 17;
  localparam int unsigned RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_255 = 18'd131587;
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned PROD_W      = BSUM_W + RECIP_W;

  // Opcodes
  localparam logic OP_FRAG  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Blend mode codes
  localparam logic [2:0] MODE_REPLACE_Z = 3'd0;
  localparam logic [2:0] MODE_OVER      = 3'd1;
  localparam logic [2:0] MODE_MOD2X     = 3'd2;
  localparam logic [2:0] MODE_ADD       = 3'd3;
  localparam logic [2:0] MODE_OVER_Z    = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BLEND_MODE   = 2'd0;
  localparam logic [1:0] REG_DEPTH_EQUAL  = 2'd1;
  localparam logic [1:0] REG_SLACK_MARGIN = 2'd2;

  localparam logic [15:0] SLACK_MARGIN_RST = 16'd168;

  // Request class decided at the front
  typedef enum logic [2:0] {
    K_CLEAR,
    K_REPLACE,
    K_OVER,
    K_OVER_Z,
    K_MOD2X,
    K_ADD
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   idx;
    logic [DEPTH_W-1:0] z;
    logic               slack;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } cmd_t;

  typedef struct packed {
    logic       color_written;
    logic       depth_written;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } res_t;

endpackage

@@ src/fdtb_front.sv @@
// Front stage: accept requests and classify them by opcode and blend mode.
module fdtb_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic                   in_opcode,
  input  logic [15:0]            in_pixel_index,
  input  logic [23:0]            in_frag_depth,
  input  logic                   in_slack_hit,
  input  logic [7:0]             in_src_red,
  input  logic [7:0]             in_src_green,
  input  logic [7:0]             in_src_blue,
  input  logic [7:0]             in_src_alpha,
  input  logic [2:0]             blend_mode,
  output logic                   q_push,
  output fdtb_pkg::cmd_t         q_data,
  input  logic                   q_full
);
  import fdtb_pkg::*;

  logic  valid_r, valid_nxt;
  cmd_t  cmd_r;
  kind_t kind;
  logic  accept;

  // Classify the incoming request
  always_comb begin
    if (in_opcode == OP_CLEAR) begin
      kind = K_CLEAR;
    end else begin
      case (blend_mode)
        MODE_OVER:   kind = K_OVER;
        MODE_OVER_Z: kind = K_OVER_Z;
        MODE_MOD2X:  kind = K_MOD2X;
        MODE_ADD:    kind = K_ADD;
        default:     kind = K_REPLACE;
      endcase
    end
  end

  // Hold while the queue is full
  assign full   = valid_r && q_full;
  assign accept = push && !full;
  assign q_push = valid_r && !q_full;
  assign q_data = cmd_r;

  assign valid_nxt = accept || (valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.kind  <= kind;
      cmd_r.idx   <= in_pixel_index;
      cmd_r.z     <= in_frag_depth;
      cmd_r.slack <= in_slack_hit;
      cmd_r.red   <= in_src_red;
      cmd_r.green <= in_src_green;
      cmd_r.blue  <= in_src_blue;
      cmd_r.alpha <= in_src_alpha;
    end
  end

endmodule

@@ src/fdtb_cmdq.sv @@
// Short request queue between the front and the back.
module fdtb_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  fdtb_pkg::cmd_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output fdtb_pkg::cmd_t  rd_data,
  output logic            valid
);
  import fdtb_pkg::*;

  cmd_t                  entries_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] count_r, count_nxt;
  logic                  do_wr, do_rd;

  assign full    = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = entries_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CMDQ_CNT_W'(do_wr) - CMDQ_CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ src/fdtb_back.sv @@
// Back end: store read, depth test, blend, store write and result queue.
module fdtb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  fdtb_pkg::cmd_t  q_data,
  output logic            q_pop,
  input  logic            depth_equal_passes,
  input  logic [15:0]     slack_depth_margin,
  output logic            empty,
  input  logic            pop,
  output fdtb_pkg::res_t  res_head
);
  import fdtb_pkg::*;

  // Color and depth stores
  logic [31:0]        color_mem [FB_PIXELS];
  logic [DEPTH_W-1:0] depth_mem [FB_PIXELS];

  // Stage 1: store data arrives
  logic               s1_v_r;
  cmd_t               s1_cmd_r;
  logic [31:0]        rd_col_r;
  logic [DEPTH_W-1:0] rd_dep_r;

  // Stage 2: blend sums ready
  logic               s2_v_r;
  cmd_t               s2_cmd_r;
  logic [31:0]        s2_col_r;
  logic               s2_wr_r;
  logic [BSUM_W-1:0]  s2_sum_r [3];

  // Stage 3: reciprocal products ready
  logic               s3_v_r;
  cmd_t               s3_cmd_r;
  logic [31:0]        s3_col_r;
  logic               s3_wr_r;
  logic [PROD_W-1:0]  s3_prod_r [3];

  // Result queue
  res_t                  resq_r [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] rq_wr_r, rq_rd_r;
  logic [RESQ_CNT_W-1:0] rq_cnt_r, rq_cnt_nxt;
  logic [RESQ_CNT_W-1:0] occupancy;

  logic               hazard, issue, rq_pop;
  logic               pass, s1_wr;
  logic [7:0]         src_ch [3];
  logic [7:0]         dst_ch [3];
  logic [BSUM_W-1:0]  sum [3];
  logic [PROD_W-1:0]  prod [3];
  logic [7:0]         blend_ch [3];
  logic [31:0]        new_col, shown_col;
  logic               s3_dw, s3_blend;
  res_t               res_new;

  // Blend dividend for one channel, before the divide by 255
  function automatic logic [BSUM_W-1:0] blend_sum(kind_t k, logic [7:0] c,
                                                  logic [7:0] d, logic [7:0] a);
    logic [15:0] ca, dn, cd;
    logic [BSUM_W-1:0] v;
    ca = 16'(c) * 16'(a);
    dn = 16'(d) * 16'(8'd255 - a);
    cd = 16'(c) * 16'(d);
    case (k)
      K_OVER, K_OVER_Z: v = BSUM_W'(ca) + BSUM_W'(dn) + BSUM_W'(127);
      K_MOD2X:          v = {cd, 1'b0} + BSUM_W'(127);
      K_ADD:            v = BSUM_W'(ca) + ({1'b0, d, 8'd0} - BSUM_W'(d)) + BSUM_W'(127);
      default:          v = '0;
    endcase
    return v;
  endfunction

  // Wait while an older request to the same pixel is still in flight
  assign hazard = (s1_v_r && s1_cmd_r.idx == q_data.idx) ||
                  (s2_v_r && s2_cmd_r.idx == q_data.idx) ||
                  (s3_v_r && s3_cmd_r.idx == q_data.idx);

  // Reserve a result slot for every request in flight
  assign occupancy = rq_cnt_r + RESQ_CNT_W'(s1_v_r) + RESQ_CNT_W'(s2_v_r)
                   + RESQ_CNT_W'(s3_v_r);
  assign issue = q_valid && !hazard && (occupancy < RESQ_CNT_W'(RESQ_DEPTH));
  assign q_pop = issue;

  // Depth test, blend sums and reciprocal products
  always_comb begin
    if (s1_cmd_r.slack) begin
      pass = ({1'b0, s1_cmd_r.z} + (DEPTH_W + 1)'(slack_depth_margin)) < {1'b0, rd_dep_r};
    end else begin
      pass = (s1_cmd_r.z < rd_dep_r) || (depth_equal_passes && s1_cmd_r.z == rd_dep_r);
    end
    s1_wr = (s1_cmd_r.kind == K_CLEAR) || (pass && s1_cmd_r.alpha != 8'd0);
    src_ch[0] = s1_cmd_r.red;
    src_ch[1] = s1_cmd_r.green;
    src_ch[2] = s1_cmd_r.blue;
    for (int k = 0; k < 3; k++) begin
      dst_ch[k] = rd_col_r[8*k +: 8];
      sum[k]    = blend_sum(s1_cmd_r.kind, src_ch[k], dst_ch[k], s1_cmd_r.alpha);
      prod[k]   = PROD_W'(s2_sum_r[k]) * PROD_W'(RECIP_255);
    end
  end

  // Quotient, saturate and merge the new pixel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      blend_ch[k] = (s3_prod_r[k][PROD_W-1:RECIP_SHIFT] > (PROD_W - RECIP_SHIFT)'(255))
                  ? 8'hFF : s3_prod_r[k][RECIP_SHIFT +: 8];
    end
    case (s3_cmd_r.kind)
      K_OVER, K_OVER_Z, K_MOD2X, K_ADD: s3_blend = 1'b1;
      default:                          s3_blend = 1'b0;
    endcase
    if (s3_blend) begin
      new_col = {8'hFF, blend_ch[2], blend_ch[1], blend_ch[0]};
    end else begin
      new_col = {s3_cmd_r.alpha, s3_cmd_r.blue, s3_cmd_r.green, s3_cmd_r.red};
    end
    case (s3_cmd_r.kind)
      K_CLEAR, K_REPLACE, K_OVER_Z: s3_dw = s3_wr_r;
      default:                      s3_dw = 1'b0;
    endcase
    shown_col             = s3_wr_r ? new_col : s3_col_r;
    res_new.color_written = s3_wr_r;
    res_new.depth_written = s3_dw;
    res_new.red           = shown_col[7:0];
    res_new.green         = shown_col[15:8];
    res_new.blue          = shown_col[23:16];
    res_new.alpha         = shown_col[31:24];
  end

  // Read and write the stores
  always_ff @(posedge clk) begin
    rd_col_r <= color_mem[q_data.idx];
    rd_dep_r <= depth_mem[q_data.idx];
    if (s3_v_r && s3_wr_r) begin
      color_mem[s3_cmd_r.idx] <= new_col;
    end
    if (s3_v_r && s3_dw) begin
      depth_mem[s3_cmd_r.idx] <= (s3_cmd_r.kind == K_CLEAR) ? DEPTH_FULL : s3_cmd_r.z;
    end
  end

  // Advance the pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Advance the pipeline payload
  always_ff @(posedge clk) begin
    s1_cmd_r <= q_data;
    s2_cmd_r <= s1_cmd_r;
    s2_col_r <= rd_col_r;
    s2_wr_r  <= s1_wr;
    s3_cmd_r <= s2_cmd_r;
    s3_col_r <= s2_col_r;
    s3_wr_r  <= s2_wr_r;
    for (int k = 0; k < 3; k++) begin
      s2_sum_r[k]  <= sum[k];
      s3_prod_r[k] <= prod[k];
    end
  end

  // Result queue
  assign empty    = (rq_cnt_r == '0);
  assign rq_pop   = pop && !empty;
  assign res_head = resq_r[rq_rd_r];
  assign rq_cnt_nxt = rq_cnt_r + RESQ_CNT_W'(s3_v_r) - RESQ_CNT_W'(rq_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (s3_v_r) begin
        rq_wr_r <= rq_wr_r + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + 1'b1;
      end
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      resq_r[rq_wr_r] <= res_new;
    end
  end

endmodule

@@ src/fragment_depth_test_blend_unit.sv @@
// A request passes the front register, request queue, back stages and result queue.
// Throughput: one request per cycle; a request to a pixel that one of the three
//   requests ahead of it still modifies waits for that store write.
// The result queue holds 8 results; requests issue only against free result slots.
// Reset (rst_n low, synchronous) empties both queues and restores the registers;
//   the color and depth stores keep their contents and are undefined until written.
module fragment_depth_test_blend_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic [15:0] in_pixel_index,
  input  logic [23:0] in_frag_depth,
  input  logic        in_slack_hit,
  input  logic [7:0]  in_src_red,
  input  logic [7:0]  in_src_green,
  input  logic [7:0]  in_src_blue,
  input  logic [7:0]  in_src_alpha,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic        out_color_written,
  output logic        out_depth_written,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fdtb_pkg::*;

  logic [2:0]  mode_r;
  logic        eq_r;
  logic [15:0] margin_r;
  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic        fq_push, fq_full, bq_pop, bq_valid;
  cmd_t        fq_data, bq_data;
  res_t        res_head;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_REPLACE_Z;
      eq_r     <= 1'b0;
      margin_r <= SLACK_MARGIN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BLEND_MODE:   mode_r   <= pwdata[2:0];
        REG_DEPTH_EQUAL:  eq_r     <= pwdata[0];
        REG_SLACK_MARGIN: margin_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLEND_MODE:   prdata = {29'd0, mode_r};
      REG_DEPTH_EQUAL:  prdata = {31'd0, eq_r};
      REG_SLACK_MARGIN: prdata = {16'd0, margin_r};
      default:          prdata = 32'd0;
    endcase
  end

  fdtb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_opcode      (in_opcode),
    .in_pixel_index (in_pixel_index),
    .in_frag_depth  (in_frag_depth),
    .in_slack_hit   (in_slack_hit),
    .in_src_red     (in_src_red),
    .in_src_green   (in_src_green),
    .in_src_blue    (in_src_blue),
    .in_src_alpha   (in_src_alpha),
    .blend_mode     (mode_r),
    .q_push         (fq_push),
    .q_data         (fq_data),
    .q_full         (fq_full)
  );

  fdtb_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_data),
    .full    (fq_full),
    .rd_en   (bq_pop),
    .rd_data (bq_data),
    .valid   (bq_valid)
  );

  fdtb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (bq_valid),
    .q_data             (bq_data),
    .q_pop              (bq_pop),
    .depth_equal_passes (eq_r),
    .slack_depth_margin (margin_r),
    .empty              (empty),
    .pop                (pop),
    .res_head           (res_head)
  );

  assign out_color_written = res_head.color_written;
  assign out_depth_written = res_head.depth_written;
  assign out_red           = res_head.red;
  assign out_green         = res_head.green;
  assign out_blue          = res_head.blue;
  assign out_alpha         = res_head.alpha;

endmodule

@@ src/fdtb_checker.sv @@
// Port-level checks of the fragment depth test and blend unit, bound to the top level.
module fdtb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        out_color_written,
  input logic        out_depth_written,
  input logic [7:0]  out_alpha,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);
  import fdtb_pkg::*;

  // Reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A depth write always comes with a color write
  a_depth_implies_color: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (!out_depth_written || out_color_written))
    else $error("depth written without color");

  // Blends that keep depth store opaque alpha
  a_blend_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_color_written && !out_depth_written) |-> (out_alpha == 8'hFF))
    else $error("blended pixel alpha not opaque");

  // A margin write reads back on the next cycle
  a_margin_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[3:2] == REG_SLACK_MARGIN)
    |=> (paddr[3:2] != REG_SLACK_MARGIN || prdata[15:0] == $past(pwdata[15:0])))
    else $error("slack margin readback mismatch");

endmodule

bind fragment_depth_test_blend_unit fdtb_checker u_fdtb_checker (.*);
